@@ rtl/cht_pkg.sv @@
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types and constants for the two-table cuckoo hash map.
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_KEY_BYTES   = 8;
  localparam int DEF_VALUE_BITS  = 32;

  // register reset values
  localparam logic [10:0] CAP_RESET    = 11'd1021;
  localparam logic [3:0]  KEYLEN_RESET = 4'd8;
  localparam logic [6:0]  THRESH_RESET = 7'd70;

  localparam logic [31:0] SDBM_INIT = 32'd0;
  localparam logic [31:0] DJB2_INIT = 32'd5381;

  typedef enum logic [1:0] {
    CFG_CAPACITY   = 2'd0,
    CFG_KEY_LENGTH = 2'd1,
    CFG_LOAD_PCT   = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_FOUND    = 3'd0,
    ST_MISS     = 3'd1,
    ST_INSERTED = 3'd2,
    ST_UPDATED  = 3'd3,
    ST_DROPPED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    HS_IDLE,
    HS_BYTE,
    HS_MOD,
    HS_DONE
  } hash_state_t;

  typedef enum logic [2:0] {
    CT_CLEAR,
    CT_IDLE,
    CT_HASH,
    CT_READ,
    CT_CHECK,
    CT_EVICT,
    CT_FINISH
  } ctrl_state_t;

endpackage

@@ rtl/cht_table.sv @@
// ----------------------------------------------------------------------------
// cht_table
// One table of slots: single write port, single registered read port.
// ----------------------------------------------------------------------------
module cht_table #(
  parameter int DEPTH = cht_pkg::DEF_TABLE_DEPTH,
  parameter int WIDTH = 1 + 8 * cht_pkg::DEF_KEY_BYTES + cht_pkg::DEF_VALUE_BITS
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/cht_hash.sv @@
// ----------------------------------------------------------------------------
// cht_hash
// Byte-serial SDBM and DJB2 hashing, then bit-serial reduction of both
// hashes modulo the capacity.
// ----------------------------------------------------------------------------
module cht_hash #(
  parameter int KEY_W = 64,
  parameter int LEN_W = 4,
  parameter int CAP_W = 11,
  parameter int IDX_W = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  input  logic [LEN_W-1:0] len,
  input  logic [CAP_W-1:0] cap,
  output logic             done,
  output logic [IDX_W-1:0] idx1,
  output logic [IDX_W-1:0] idx2
);

  cht_pkg::hash_state_t hs_r, hs_nxt;

  logic [KEY_W-1:0] sh_r;
  logic [LEN_W-1:0] byte_r;
  logic [4:0]       bit_r;
  logic [31:0]      h1_r, h2_r;
  logic [CAP_W:0]   r1_r, r2_r;
  logic [CAP_W-1:0] cap_r;
  logic [31:0]      c;
  logic [CAP_W:0]   t1, t2;

  assign c  = 32'(sh_r[7:0]);
  assign t1 = {r1_r[CAP_W-1:0], h1_r[31]};
  assign t2 = {r2_r[CAP_W-1:0], h2_r[31]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_r <= cht_pkg::HS_IDLE;
    end else begin
      hs_r <= hs_nxt;
    end
  end

  always_comb begin
    hs_nxt = hs_r;
    done   = 1'b0;
    unique case (hs_r)
      cht_pkg::HS_IDLE: if (start) hs_nxt = cht_pkg::HS_BYTE;
      cht_pkg::HS_BYTE: if (byte_r == LEN_W'(1)) hs_nxt = cht_pkg::HS_MOD;
      cht_pkg::HS_MOD:  if (bit_r == 5'd0) hs_nxt = cht_pkg::HS_DONE;
      cht_pkg::HS_DONE: begin
        done   = 1'b1;
        hs_nxt = cht_pkg::HS_IDLE;
      end
      default: hs_nxt = cht_pkg::HS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (hs_r)
      cht_pkg::HS_IDLE: begin
        if (start) begin
          sh_r   <= key;
          byte_r <= len;
          cap_r  <= cap;
          h1_r   <= cht_pkg::SDBM_INIT;
          h2_r   <= cht_pkg::DJB2_INIT;
        end
      end
      cht_pkg::HS_BYTE: begin
        h1_r   <= c + (h1_r << 6) + (h1_r << 16) - h1_r;
        h2_r   <= (h2_r << 5) + h2_r + c;
        sh_r   <= sh_r >> 8;
        byte_r <= byte_r - LEN_W'(1);
        bit_r  <= 5'd31;
        r1_r   <= '0;
        r2_r   <= '0;
      end
      cht_pkg::HS_MOD: begin
        // restoring remainder, one hash bit per cycle, msb first
        r1_r  <= (t1 >= {1'b0, cap_r}) ? t1 - {1'b0, cap_r} : t1;
        r2_r  <= (t2 >= {1'b0, cap_r}) ? t2 - {1'b0, cap_r} : t2;
        h1_r  <= h1_r << 1;
        h2_r  <= h2_r << 1;
        bit_r <= bit_r - 5'd1;
      end
      default: begin
      end
    endcase
  end

  // remainder is below capacity, which never exceeds the table depth
  assign idx1 = r1_r[IDX_W-1:0];
  assign idx2 = r2_r[IDX_W-1:0];

endmodule

@@ rtl/cuckoo_hash_table.sv @@
// ----------------------------------------------------------------------------
// cuckoo_hash_table
// Two-table cuckoo map with byte-serial hashing and bounded eviction walk.
// ----------------------------------------------------------------------------
// Lookup or update: after the input transfer, key_length byte steps and 32
// remainder steps in the shared unit, then a table read and a check raise out_tvalid.
// Insert: after the check, an eviction walk that rehashes each displaced key,
// up to 2*capacity bounces. One item at a time; in_tready is high only while
// idle, and a held result stalls the block.
// Reset: synchronous; a clearing pass over every slot empties both
// tables before the first input transfer. Config writes are taken at any time.
module cuckoo_hash_table #(
  parameter int TABLE_DEPTH = cht_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_BYTES   = cht_pkg::DEF_KEY_BYTES,
  parameter int VALUE_BITS  = cht_pkg::DEF_VALUE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // key[63:0], value_in[95:64]
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // value_out[31:0], grow_needed[32], entry_count[44:33]
  output logic [2:0]  out_tuser,  // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int KEY_W = 8 * KEY_BYTES;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CAP_W = $clog2(TABLE_DEPTH + 1);
  localparam int LEN_W = $clog2(KEY_BYTES + 1);
  localparam int ENT_W = 1 + KEY_W + VALUE_BITS;
  localparam int PRD_W = CAP_W + 7;

  cht_pkg::ctrl_state_t state_r, state_nxt;

  logic [10:0]           cap_cfg_r;
  logic [3:0]            len_cfg_r;
  logic [6:0]            thr_r;
  logic                  action_r;
  logic [KEY_W-1:0]      key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [KEY_W-1:0]      ck_r, ck_nxt;
  logic [VALUE_BITS-1:0] cv_r, cv_nxt;
  logic                  in_first_r, in_first_nxt;
  logic [CAP_W:0]        bounce_r, bounce_nxt;
  logic [CAP_W-1:0]      cnt1_r, cnt1_nxt, cnt2_r, cnt2_nxt;
  cht_pkg::status_t      status_r, status_nxt;
  logic [VALUE_BITS-1:0] vout_r, vout_nxt;
  logic [IDX_W-1:0]      clr_r;
  logic                  out_valid_r;
  logic [47:0]           out_data_r;
  logic [2:0]            out_user_r;

  logic [CAP_W-1:0] cap_eff;
  logic [LEN_W-1:0] len_eff;
  logic [KEY_W-1:0] kmask;
  logic [CAP_W:0]   limit;

  logic             h_start, h_done;
  logic [KEY_W-1:0] h_key;
  logic [IDX_W-1:0] h_idx1, h_idx2;

  logic             t1_we, t2_we;
  logic [IDX_W-1:0] t1_waddr, t2_waddr;
  logic [ENT_W-1:0] t1_wdata, t2_wdata, t1_rdata, t2_rdata, new_ent;

  logic                  d1_valid, d2_valid, hit1, hit2;
  logic [KEY_W-1:0]      d1_key, d2_key, cur_key;
  logic [VALUE_BITS-1:0] d1_val, d2_val, cur_val;
  logic                  cur_valid;

  logic             accept, out_load;
  logic [PRD_W-1:0] lhs1, lhs2, rhs;
  logic             grow;
  logic [CAP_W:0]   total;

  // effective register values
  always_comb begin
    if (cap_cfg_r == 11'd0) cap_eff = CAP_W'(1);
    else if (32'(cap_cfg_r) > TABLE_DEPTH) cap_eff = CAP_W'(TABLE_DEPTH);
    else cap_eff = CAP_W'(cap_cfg_r);
    if (len_cfg_r == 4'd0) len_eff = LEN_W'(1);
    else if (32'(len_cfg_r) > KEY_BYTES) len_eff = LEN_W'(KEY_BYTES);
    else len_eff = LEN_W'(len_cfg_r);
    for (int b = 0; b < KEY_BYTES; b++) begin
      kmask[b*8 +: 8] = (32'(len_eff) > b) ? 8'hFF : 8'h00;
    end
  end

  assign limit = {cap_eff, 1'b0};

  // table entry layout: {valid, key, value}
  assign d1_valid = t1_rdata[ENT_W-1];
  assign d1_key   = t1_rdata[VALUE_BITS +: KEY_W];
  assign d1_val   = t1_rdata[VALUE_BITS-1:0];
  assign d2_valid = t2_rdata[ENT_W-1];
  assign d2_key   = t2_rdata[VALUE_BITS +: KEY_W];
  assign d2_val   = t2_rdata[VALUE_BITS-1:0];

  assign hit1 = d1_valid && (((d1_key ^ key_r) & kmask) == '0);
  assign hit2 = d2_valid && (((d2_key ^ key_r) & kmask) == '0);

  assign cur_valid = in_first_r ? d1_valid : d2_valid;
  assign cur_key   = in_first_r ? d1_key : d2_key;
  assign cur_val   = in_first_r ? d1_val : d2_val;
  assign new_ent   = {1'b1, ck_r, cv_r};

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == cht_pkg::CT_IDLE);
  assign cfg_ready = 1'b1;

  // load check: floor(n*100/cap) >= thr  <=>  n*100 >= thr*cap
  assign lhs1  = PRD_W'(cnt1_r) * PRD_W'(100);
  assign lhs2  = PRD_W'(cnt2_r) * PRD_W'(100);
  assign rhs   = PRD_W'(thr_r) * PRD_W'(cap_eff);
  assign grow  = (lhs1 >= rhs) || (lhs2 >= rhs);
  assign total = {1'b0, cnt1_r} + {1'b0, cnt2_r};

  assign out_load = (state_r == cht_pkg::CT_FINISH) && (!out_valid_r || out_tready);

  cht_hash #(
    .KEY_W (KEY_W),
    .LEN_W (LEN_W),
    .CAP_W (CAP_W),
    .IDX_W (IDX_W)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (h_start),
    .key   (h_key),
    .len   (len_eff),
    .cap   (cap_eff),
    .done  (h_done),
    .idx1  (h_idx1),
    .idx2  (h_idx2)
  );

  cht_table #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENT_W)
  ) u_first (
    .clk     (clk),
    .wr_en   (t1_we),
    .wr_addr (t1_waddr),
    .wr_data (t1_wdata),
    .rd_addr (h_idx1),
    .rd_data (t1_rdata)
  );

  cht_table #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENT_W)
  ) u_second (
    .clk     (clk),
    .wr_en   (t2_we),
    .wr_addr (t2_waddr),
    .wr_data (t2_wdata),
    .rd_addr (h_idx2),
    .rd_data (t2_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    ck_nxt       = ck_r;
    cv_nxt       = cv_r;
    in_first_nxt = in_first_r;
    bounce_nxt   = bounce_r;
    cnt1_nxt     = cnt1_r;
    cnt2_nxt     = cnt2_r;
    status_nxt   = status_r;
    vout_nxt     = vout_r;
    h_start      = 1'b0;
    h_key        = KEY_W'(in_tdata[63:0]);
    t1_we        = 1'b0;
    t2_we        = 1'b0;
    t1_waddr     = h_idx1;
    t2_waddr     = h_idx2;
    t1_wdata     = new_ent;
    t2_wdata     = new_ent;

    unique case (state_r)
      cht_pkg::CT_CLEAR: begin
        t1_we    = 1'b1;
        t2_we    = 1'b1;
        t1_waddr = clr_r;
        t2_waddr = clr_r;
        t1_wdata = '0;
        t2_wdata = '0;
        if (clr_r == IDX_W'(TABLE_DEPTH - 1)) state_nxt = cht_pkg::CT_IDLE;
      end
      cht_pkg::CT_IDLE: begin
        if (accept) begin
          h_start      = 1'b1;
          in_first_nxt = 1'b1;
          bounce_nxt   = '0;
          vout_nxt     = '0;
          state_nxt    = cht_pkg::CT_HASH;
        end
      end
      cht_pkg::CT_HASH: begin
        if (h_done) state_nxt = cht_pkg::CT_READ;
      end
      cht_pkg::CT_READ: begin
        state_nxt = (bounce_r == '0 && !in_first_r) ? cht_pkg::CT_EVICT :
                    (bounce_r != '0) ? cht_pkg::CT_EVICT : cht_pkg::CT_CHECK;
      end
      cht_pkg::CT_CHECK: begin
        state_nxt = cht_pkg::CT_FINISH;
        if (!action_r) begin
          if (hit1) begin
            status_nxt = cht_pkg::ST_FOUND;
            vout_nxt   = d1_val;
          end else if (hit2) begin
            status_nxt = cht_pkg::ST_FOUND;
            vout_nxt   = d2_val;
          end else begin
            status_nxt = cht_pkg::ST_MISS;
          end
        end else if (hit1) begin
          t1_we      = 1'b1;
          t1_wdata   = {1'b1, d1_key, val_r};
          status_nxt = cht_pkg::ST_UPDATED;
        end else if (hit2) begin
          t2_we      = 1'b1;
          t2_wdata   = {1'b1, d2_key, val_r};
          status_nxt = cht_pkg::ST_UPDATED;
        end else begin
          // start the walk at the new key's table-one slot, already read
          ck_nxt     = key_r;
          cv_nxt     = val_r;
          status_nxt = cht_pkg::ST_DROPPED;
          state_nxt  = cht_pkg::CT_EVICT;
        end
      end
      cht_pkg::CT_EVICT: begin
        t1_we = in_first_r;
        t2_we = !in_first_r;
        if (!cur_valid) begin
          if (in_first_r) cnt1_nxt = cnt1_r + CAP_W'(1);
          else cnt2_nxt = cnt2_r + CAP_W'(1);
          status_nxt = cht_pkg::ST_INSERTED;
          state_nxt  = cht_pkg::CT_FINISH;
        end else begin
          ck_nxt       = cur_key;
          cv_nxt       = cur_val;
          in_first_nxt = !in_first_r;
          bounce_nxt   = bounce_r + (CAP_W+1)'(1);
          if (bounce_nxt >= limit) begin
            state_nxt = cht_pkg::CT_FINISH;
          end else begin
            h_start   = 1'b1;
            h_key     = cur_key;
            state_nxt = cht_pkg::CT_HASH;
          end
        end
      end
      cht_pkg::CT_FINISH: begin
        if (out_load) state_nxt = cht_pkg::CT_IDLE;
      end
      default: state_nxt = cht_pkg::CT_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cht_pkg::CT_CLEAR;
      clr_r       <= '0;
      cap_cfg_r   <= cht_pkg::CAP_RESET;
      len_cfg_r   <= cht_pkg::KEYLEN_RESET;
      thr_r       <= cht_pkg::THRESH_RESET;
      cnt1_r      <= '0;
      cnt2_r      <= '0;
      out_valid_r <= 1'b0;
      in_first_r  <= 1'b1;
      bounce_r    <= '0;
      status_r    <= cht_pkg::ST_MISS;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_r + IDX_W'(1);
      cnt1_r     <= cnt1_nxt;
      cnt2_r     <= cnt2_nxt;
      in_first_r <= in_first_nxt;
      bounce_r   <= bounce_nxt;
      status_r   <= status_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          cht_pkg::CFG_CAPACITY:   cap_cfg_r <= cfg_data;
          cht_pkg::CFG_KEY_LENGTH: len_cfg_r <= cfg_data[3:0];
          cht_pkg::CFG_LOAD_PCT:   thr_r     <= cfg_data[6:0];
          default: begin
          end
        endcase
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ck_r   <= ck_nxt;
    cv_r   <= cv_nxt;
    vout_r <= vout_nxt;
    if (accept) begin
      action_r <= in_tuser;
      key_r    <= KEY_W'(in_tdata[63:0]);
      val_r    <= VALUE_BITS'(in_tdata[95:64]);
    end
    if (out_load) begin
      out_data_r <= {3'b000, 12'(total), grow, 32'(64'(vout_r))};
      out_user_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
